/* hdl/crc32_message_deframer_defines.svh */
// Assertion macros for the CRC-32 message deframer.
// Included by the top level; the clock and reset come from the including module.
`ifndef CRC32_MESSAGE_DEFRAMER_DEFINES_SVH
`define CRC32_MESSAGE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define CDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define CDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/crcdfr_pkg.sv */
// Shared types, constants and the bytewise CRC-32 update for the message deframer.
// No dependencies.
`default_nettype none

package crcdfr_pkg;

  localparam logic [31:0] CrcSeed = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  // Header byte boundaries (exclusive ends of each big-endian field).
  localparam logic [4:0] LenEnd   = 5'd4;
  localparam logic [4:0] TypeEnd  = 5'd6;
  localparam logic [4:0] FlagsEnd = 5'd7;
  localparam logic [4:0] AgentEnd = 5'd11;
  localparam logic [4:0] TagEnd   = 5'd15;
  localparam logic [4:0] HdrBytes = 5'd23;

  // Index of the last trailer byte.
  localparam logic [31:0] TrlLast = 32'd3;

  localparam logic KindPayload = 1'b0;
  localparam logic KindEnd     = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] msg_type;
    logic [7:0]  msg_flags;
    logic [31:0] agent;
    logic [31:0] header_tag;
    logic [63:0] time_stamp;
    logic [31:0] payload_length;
    logic [31:0] received_crc;
    logic        crc_ok;
  } res_t;

  function automatic logic [31:0] crc_feed(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/crc32_message_deframer.sv */
// Top level of the length-prefixed frame deframer with CRC-32 check.
// Depends on crcdfr_pkg and crc32_message_deframer_defines.svh.
//
//   Channel | Valid        | Stall        | Payload
//   rx      | rx_valid_i   | rx_stall_o   | rx_byte_i
//   res     | res_valid_o  | res_stall_i  | kind_o ... crc_ok_o
//
// One byte is accepted per cycle unless rx_stall_o is high; the frame state and CRC
// are updated in the cycle of the transfer, and any result is registered alongside them.
// The bytewise CRC update and the 32-bit payload count compare set the cycle time.
// A two-entry result buffer (output register plus skid register) lets a byte be
// accepted while a result waits; rx_stall_o rises only when the skid entry is full.
// Reset is asynchronous and active low and needs no clearing pass.
`default_nettype none
`include "crc32_message_deframer_defines.svh"

module crc32_message_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rx_valid_i,
  output logic             rx_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             res_valid_o,
  input  wire logic        res_stall_i,
  output logic             kind_o,
  output logic [7:0]       data_byte_o,
  output logic [15:0]      msg_type_o,
  output logic [7:0]       msg_flags_o,
  output logic [31:0]      agent_o,
  output logic [31:0]      header_tag_o,
  output logic [63:0]      time_stamp_o,
  output logic [31:0]      payload_length_o,
  output logic [31:0]      received_crc_o,
  output logic             crc_ok_o
);

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhTrailer = 2'd2
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [31:0]        pos_q, pos_d;
  logic [31:0]        crc_q, crc_d;
  logic [31:0]        len_q, len_d;
  logic [15:0]        type_q, type_d;
  logic [7:0]         flags_q, flags_d;
  logic [31:0]        agent_q, agent_d;
  logic [31:0]        tag_q, tag_d;
  logic [63:0]        stamp_q, stamp_d;
  logic [31:0]        trl_q, trl_d;

  crcdfr_pkg::res_t   res_new;
  logic               res_gen;
  crcdfr_pkg::res_t   out_q;
  crcdfr_pkg::res_t   skid_q;
  logic               out_valid_q;
  logic               skid_valid_q;

  logic               rx_fire;
  logic               out_take;
  logic [31:0]        pos_inc;
  logic [31:0]        trl_full;
  logic [31:0]        hdr_crc;
  logic [4:0]         hdr_pos;
  logic [4:0]         hdr_next;

  assign rx_stall_o = skid_valid_q;
  assign rx_fire    = rx_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !res_stall_i;
  assign pos_inc    = pos_q + 32'd1;
  assign trl_full   = {trl_q[23:0], rx_byte_i};
  // The unused phase code restarts a frame, so the header works from fresh values.
  assign hdr_pos    = (phase_q == PhHeader) ? pos_q[4:0] : 5'd0;
  assign hdr_crc    = (phase_q == PhHeader) ? crc_q : crcdfr_pkg::CrcSeed;
  assign hdr_next   = hdr_pos + 5'd1;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    len_d   = len_q;
    type_d  = type_q;
    flags_d = flags_q;
    agent_d = agent_q;
    tag_d   = tag_q;
    stamp_d = stamp_q;
    trl_d   = trl_q;
    res_gen = 1'b0;
    res_new = '0;
    if (rx_fire) begin
      case (phase_q)
        PhPayload: begin
          crc_d             = crcdfr_pkg::crc_feed(crc_q, rx_byte_i);
          res_gen           = 1'b1;
          res_new.kind      = crcdfr_pkg::KindPayload;
          res_new.data_byte = rx_byte_i;
          if (pos_inc == len_q) begin
            phase_d = PhTrailer;
            pos_d   = 32'd0;
          end else begin
            pos_d = pos_inc;
          end
        end
        PhTrailer: begin
          trl_d = trl_full;
          pos_d = pos_inc;
          if (pos_q == crcdfr_pkg::TrlLast) begin
            res_gen                = 1'b1;
            res_new.kind           = crcdfr_pkg::KindEnd;
            res_new.msg_type       = type_q;
            res_new.msg_flags      = flags_q;
            res_new.agent          = agent_q;
            res_new.header_tag     = tag_q;
            res_new.time_stamp     = stamp_q;
            res_new.payload_length = len_q;
            res_new.received_crc   = trl_full;
            res_new.crc_ok         = (~crc_q == trl_full);
            phase_d                = PhHeader;
            pos_d                  = 32'd0;
            crc_d                  = crcdfr_pkg::CrcSeed;
          end
        end
        default: begin
          crc_d = crcdfr_pkg::crc_feed(hdr_crc, rx_byte_i);
          if (hdr_pos < crcdfr_pkg::LenEnd) begin
            len_d = {len_q[23:0], rx_byte_i};
          end else if (hdr_pos < crcdfr_pkg::TypeEnd) begin
            type_d = {type_q[7:0], rx_byte_i};
          end else if (hdr_pos < crcdfr_pkg::FlagsEnd) begin
            flags_d = rx_byte_i;
          end else if (hdr_pos < crcdfr_pkg::AgentEnd) begin
            agent_d = {agent_q[23:0], rx_byte_i};
          end else if (hdr_pos < crcdfr_pkg::TagEnd) begin
            tag_d = {tag_q[23:0], rx_byte_i};
          end else begin
            stamp_d = {stamp_q[55:0], rx_byte_i};
          end
          if (hdr_next >= crcdfr_pkg::HdrBytes) begin
            pos_d   = 32'd0;
            trl_d   = 32'd0;
            phase_d = (len_q == 32'd0) ? PhTrailer : PhPayload;
          end else begin
            phase_d = PhHeader;
            pos_d   = {27'd0, hdr_next};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_q   <= 32'd0;
      crc_q   <= crcdfr_pkg::CrcSeed;
      len_q   <= 32'd0;
      type_q  <= 16'd0;
      flags_q <= 8'd0;
      agent_q <= 32'd0;
      tag_q   <= 32'd0;
      stamp_q <= 64'd0;
      trl_q   <= 32'd0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      len_q   <= len_d;
      type_q  <= type_d;
      flags_q <= flags_d;
      agent_q <= agent_d;
      tag_q   <= tag_d;
      stamp_q <= stamp_d;
      trl_q   <= trl_d;
    end
  end

  // A new result goes straight to the output register when it is free or being
  // emptied; otherwise it parks in the skid register, which stalls the input.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_gen) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_gen) begin
      if (!out_valid_q || out_take) begin
        out_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  assign res_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign data_byte_o      = out_q.data_byte;
  assign msg_type_o       = out_q.msg_type;
  assign msg_flags_o      = out_q.msg_flags;
  assign agent_o          = out_q.agent;
  assign header_tag_o     = out_q.header_tag;
  assign time_stamp_o     = out_q.time_stamp;
  assign payload_length_o = out_q.payload_length;
  assign received_crc_o   = out_q.received_crc;
  assign crc_ok_o         = out_q.crc_ok;

  `CDF_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid entry without output entry")
  `CDF_ASSERT_NOW(a_payload_nonzero_len, phase_q == PhPayload, len_q != 32'd0, "payload phase with zero length")
  `CDF_ASSERT_NOW(a_payload_clean, out_valid_q && out_q.kind == crcdfr_pkg::KindPayload, !out_q.crc_ok && out_q.received_crc == 32'd0, "payload result carries frame fields")
  `CDF_ASSERT_NEXT(a_end_resets_crc, rx_fire && res_gen && res_new.kind == crcdfr_pkg::KindEnd, crc_q == crcdfr_pkg::CrcSeed && phase_q == PhHeader, "frame end did not restart CRC")

endmodule

`default_nettype wire

/* tb/tb_crc32_message_deframer.sv */
// Self-checking testbench for crc32_message_deframer: streams length-prefixed frames
// byte by byte and checks every payload byte and end-of-frame record in order.
// Depends on crcdfr_pkg and the deframer RTL; needs no files or arguments.

module tb_crc32_message_deframer;

  localparam int QuietLimit = 3000;

  typedef enum logic [1:0] {PhHeader, PhPayload, PhTrailer} parse_phase_e;
  typedef enum int {StallNone, StallRandom, StallPattern} stall_mode_e;
  typedef enum int {FillRandom, FillAlternate} fill_e;
  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [31:0] len;
    logic [15:0] mtype;
    logic [7:0]  flags;
    logic [31:0] agent;
    logic [31:0] tag;
    logic [63:0] stamp;
  } frame_hdr_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        rx_valid_i = 1'b0;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  logic        kind_o;
  logic [7:0]  data_byte_o;
  logic [15:0] msg_type_o;
  logic [7:0]  msg_flags_o;
  logic [31:0] agent_o;
  logic [31:0] header_tag_o;
  logic [63:0] time_stamp_o;
  logic [31:0] payload_length_o;
  logic [31:0] received_crc_o;
  logic        crc_ok_o;

  crc32_message_deframer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_stall_o       (rx_stall_o),
    .rx_byte_i        (rx_byte_i),
    .res_valid_o      (res_valid_o),
    .res_stall_i      (res_stall_i),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .msg_type_o       (msg_type_o),
    .msg_flags_o      (msg_flags_o),
    .agent_o          (agent_o),
    .header_tag_o     (header_tag_o),
    .time_stamp_o     (time_stamp_o),
    .payload_length_o (payload_length_o),
    .received_crc_o   (received_crc_o),
    .crc_ok_o         (crc_ok_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Parser state mirrored by the testbench.
  parse_phase_e ph = PhHeader;
  logic [31:0]  pos = '0;
  logic [31:0]  run_crc = crcdfr_pkg::CrcSeed;
  logic [31:0]  len_q = '0;
  logic [15:0]  type_q = '0;
  logic [7:0]   flags_q = '0;
  logic [31:0]  agent_q = '0;
  logic [31:0]  tag_q = '0;
  logic [63:0]  stamp_q = '0;
  logic [31:0]  trl_q = '0;

  crcdfr_pkg::res_t expected_results[$];
  crcdfr_pkg::res_t want_res;
  int          error_count = 0;
  int          sent_count = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b0;
  stall_mode_e stall_mode = StallNone;
  int          stall_tick = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c;
    for (int i = 0; i < 8; i++) begin
      x = (x >> 1) ^ ((x[0] ^ b[i]) ? crcdfr_pkg::CrcPoly : 32'd0);
    end
    return x;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    crcdfr_pkg::res_t r;
    r = '0;
    case (ph)
      PhPayload: begin
        run_crc = crc_byte(run_crc, b);
        r.kind = crcdfr_pkg::KindPayload;
        r.data_byte = b;
        expected_results = {expected_results, r};
        pos++;
        if (pos == len_q) begin
          ph = PhTrailer;
          pos = '0;
        end
      end
      PhTrailer: begin
        trl_q = {trl_q[23:0], b};
        pos++;
        if (pos > crcdfr_pkg::TrlLast) begin
          r.kind = crcdfr_pkg::KindEnd;
          r.msg_type = type_q;
          r.msg_flags = flags_q;
          r.agent = agent_q;
          r.header_tag = tag_q;
          r.time_stamp = stamp_q;
          r.payload_length = len_q;
          r.received_crc = trl_q;
          r.crc_ok = (~run_crc == trl_q);
          expected_results = {expected_results, r};
          ph = PhHeader;
          pos = '0;
          run_crc = crcdfr_pkg::CrcSeed;
        end
      end
      default: begin
        run_crc = crc_byte(run_crc, b);
        if (pos < crcdfr_pkg::LenEnd) len_q = {len_q[23:0], b};
        else if (pos < crcdfr_pkg::TypeEnd) type_q = {type_q[7:0], b};
        else if (pos < crcdfr_pkg::FlagsEnd) flags_q = b;
        else if (pos < crcdfr_pkg::AgentEnd) agent_q = {agent_q[23:0], b};
        else if (pos < crcdfr_pkg::TagEnd) tag_q = {tag_q[23:0], b};
        else stamp_q = {stamp_q[55:0], b};
        pos++;
        if (pos >= crcdfr_pkg::HdrBytes) begin
          pos = '0;
          trl_q = '0;
          ph = (len_q == 0) ? PhTrailer : PhPayload;
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: kind %0b data_byte %0h", kind_o, data_byte_o);
        error_count++;
      end else begin
        want_res = expected_results.pop_front();
        check_field("kind", want_res.kind, kind_o);
        check_field("data_byte", want_res.data_byte, data_byte_o);
        check_field("msg_type", want_res.msg_type, msg_type_o);
        check_field("msg_flags", want_res.msg_flags, msg_flags_o);
        check_field("agent", want_res.agent, agent_o);
        check_field("header_tag", want_res.header_tag, header_tag_o);
        check_field("time_stamp", want_res.time_stamp, time_stamp_o);
        check_field("payload_length", want_res.payload_length, payload_length_o);
        check_field("received_crc", want_res.received_crc, received_crc_o);
        check_field("crc_ok", want_res.crc_ok, crc_ok_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rx_valid_i && !rx_stall_o) || (res_valid_o && !res_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result-side stall; a requested hold-off overrides the current pattern.
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    stall_tick = (stall_tick + 1) % 11;
    if (hold_left != 0) begin
      hold_left--;
      res_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        StallRandom:  res_stall_i <= ($urandom_range(0, 99) < 35);
        StallPattern: res_stall_i <= 1'(11'b00110001110 >> stall_tick);
        default:      res_stall_i <= 1'b0;
      endcase
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        rx_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    burst_left--;
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (rx_stall_o);
    deframe_byte(b);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_bytes(input byte_q_t q, input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(q[i]);
    end
  endtask

  function automatic frame_hdr_t rand_hdr(input logic [31:0] len);
    frame_hdr_t h;
    h.len = len;
    h.mtype = 16'($urandom);
    h.flags = 8'($urandom);
    h.agent = $urandom;
    h.tag = $urandom;
    h.stamp = {$urandom, $urandom};
    return h;
  endfunction

  function automatic byte_q_t frame_bytes(input frame_hdr_t h, input int body_len,
                                          input fill_e fill, input logic [31:0] crc_flip);
    byte_q_t     q;
    logic [31:0] c;
    logic [183:0] hdr;
    hdr = {h.len, h.mtype, h.flags, h.agent, h.tag, h.stamp};
    for (int i = 22; i >= 0; i--) q = {q, hdr[i*8 +: 8]};
    for (int i = 0; i < body_len; i++) begin
      q = {q, (fill == FillAlternate) ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom)};
    end
    c = crcdfr_pkg::CrcSeed;
    foreach (q[i]) c = crc_byte(c, q[i]);
    c = ~c ^ crc_flip;
    for (int i = 3; i >= 0; i--) q = {q, c[i*8 +: 8]};
    return q;
  endfunction

  task automatic send_frame(input frame_hdr_t h, input fill_e fill, input logic [31:0] crc_flip);
    byte_q_t q;
    q = frame_bytes(h, h.len, fill, crc_flip);
    send_bytes(q, q.size());
  endtask

  // Feeds filler bytes until the parser is back at the start of a header.
  // Length bytes are zero so the recovery frame stays short.
  task automatic resync();
    while (!(ph == PhHeader && pos == 0)) begin
      if (ph == PhHeader && pos < crcdfr_pkg::LenEnd) send_byte(8'h00);
      else send_byte(8'($urandom));
    end
  endtask

  task automatic test_header_extremes();
    frame_hdr_t h;
    gaps_on = 1'b0;
    stall_mode = StallNone;
    h = '{len: 32'd4, mtype: 16'hFFFF, flags: 8'hFF, agent: 32'hFFFF_FFFF,
          tag: 32'hFFFF_FFFF, stamp: 64'hFFFF_FFFF_FFFF_FFFF};
    send_frame(h, FillAlternate, 32'd0);
    // Empty payload: the trailer follows the header directly.
    h = '{len: 32'd0, mtype: 16'h0000, flags: 8'h00, agent: 32'd0, tag: 32'd0, stamp: 64'd0};
    send_frame(h, FillRandom, 32'd0);
  endtask

  task automatic test_crc_mismatch();
    gaps_on = 1'b1;
    stall_mode = StallPattern;
    send_frame(rand_hdr(32'd2), FillRandom, 32'h0000_0001);
    send_frame(rand_hdr(32'd0), FillRandom, 32'h8000_0000);
    send_frame(rand_hdr(32'd1), FillRandom, 32'd0);
  endtask

  task automatic test_long_payload();
    gaps_on = 1'b1;
    stall_mode = StallRandom;
    send_frame(rand_hdr(32'd64), FillRandom, 32'd0);
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    stall_mode = StallNone;
    hold_request = 150;
    send_frame(rand_hdr(32'd40), FillRandom, 32'd0);
  endtask

  task automatic test_random_stream();
    byte_q_t q;
    int      start;
    int      sel;
    int      len;
    start = sent_count;
    while (sent_count - start < 100) begin
      gaps_on = $urandom_range(0, 1);
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (sel < 75) begin
        send_frame(rand_hdr(len), FillRandom, 32'd0);
      end else if (sel < 87) begin
        send_frame(rand_hdr(len), FillRandom, $urandom_range(1, 32'hFFFF_FFFF));
      end else begin
        // Truncated frame, cut after the length field, then recovery filler.
        q = frame_bytes(rand_hdr(len), len, FillRandom, 32'd0);
        send_bytes(q, $urandom_range(crcdfr_pkg::LenEnd, q.size() - 1));
        resync();
      end
    end
  endtask

  // The length is counted in full, so the block stays in the payload phase
  // for the rest of the run; this test must come last.
  task automatic test_large_length();
    byte_q_t q;
    gaps_on = 1'b1;
    stall_mode = StallRandom;
    q = frame_bytes(rand_hdr(32'hFFFF_FFFF), 20, FillRandom, 32'd0);
    send_bytes(q, q.size() - 4);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_header_extremes();
    test_crc_mismatch();
    test_long_payload();
    test_backpressure();
    test_random_stream();
    test_large_length();
    rx_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/crcdfr_pkg.sv
hdl/crc32_message_deframer.sv
tb/tb_crc32_message_deframer.sv
